### hw/rtl/mrd_pkg.sv
// mrd_pkg: shared constants, item types and the crc-16 byte update
// for the modbus rtu response deframer; no dependencies
package mrd_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_BEGIN   = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_FRAME     = 3'd2;
    localparam logic [2:0] ST_CRC       = 3'd3;
    localparam logic [2:0] ST_EXCEPTION = 3'd4;

    // function codes and frame constants
    localparam logic [7:0]  FN_READ_HOLD  = 8'h03;
    localparam logic [7:0]  FN_READ_INPUT = 8'h04;
    localparam logic [7:0]  FN_EXC_MASK   = 8'h80;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [8:0]  LEN_EXCEPTION = 9'd5;
    localparam logic [8:0]  LEN_FIXED     = 9'd8;
    localparam logic [8:0]  LEN_READ_BASE = 9'd5;

    // default word limit
    localparam int MAX_WORDS_DEF = 125;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [6:0] expected_words;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] word_value;
        logic [6:0]  word_index;
        logic [2:0]  status_code;
        logic [7:0]  exception_code;
    } t_out_item;

    // reflected crc-16 update by one octet, lsb first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [7:0]  octet);
        logic [15:0] c;
        c = crc ^ {8'h00, octet};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // read holding or read input function code
    function automatic logic is_read_fn(input logic [7:0] fn);
        return (fn == FN_READ_HOLD) || (fn == FN_READ_INPUT);
    endfunction

endpackage

### hw/rtl/mrd_channels.sv
// mrd_channels: valid/ready channel interfaces for request and result items
// no package dependency; field widths follow the item definitions
interface mrd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [6:0] expected_words;

    modport source (output valid, output req_type, output rx_byte,
                    output expected_words, input ready);
    modport sink   (input valid, input req_type, input rx_byte,
                    input expected_words, output ready);
endinterface

interface mrd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [2:0]  status_code;
    logic [7:0]  exception_code;

    modport source (output valid, output result_kind, output word_value,
                    output word_index, output status_code,
                    output exception_code, input ready);
    modport sink   (input valid, input result_kind, input word_value,
                    input word_index, input status_code,
                    input exception_code, output ready);
endinterface

### hw/rtl/mrd_engine.sv
// mrd_engine: frame state, crc-16 check and result decision for one item
// per cycle while i_fire is high; depends on mrd_pkg
module mrd_engine #(
    parameter int MAX_WORDS = mrd_pkg::MAX_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  mrd_pkg::t_in_item    i_item,
    output logic                 o_res_vld,
    output mrd_pkg::t_out_item   o_res
);
    import mrd_pkg::*;

    localparam logic [6:0] MaxW = 7'(MAX_WORDS);

    logic [15:0] r_crc,    n_crc;
    logic [8:0]  r_rcvd,   n_rcvd;
    logic [8:0]  r_flen,   n_flen;
    logic [7:0]  r_fn,     n_fn;
    logic [7:0]  r_cnt,    n_cnt;
    logic [7:0]  r_hi,     n_hi;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [6:0]  r_want,   n_want;
    logic [6:0]  r_emit,   n_emit;
    logic        r_done,   n_done;

    logic [9:0]  w_pos_p2;
    logic [15:0] w_rx_crc;
    logic [7:0]  w_twice_want;

    assign w_pos_p2     = {1'b0, r_rcvd} + 10'd2;
    assign w_rx_crc     = {i_item.rx_byte, r_crc_lo};
    assign w_twice_want = {r_want, 1'b0};

    // next state and result for the item in flight
    always_comb begin
        n_crc     = r_crc;
        n_rcvd    = r_rcvd;
        n_flen    = r_flen;
        n_fn      = r_fn;
        n_cnt     = r_cnt;
        n_hi      = r_hi;
        n_crc_lo  = r_crc_lo;
        n_want    = r_want;
        n_emit    = r_emit;
        n_done    = r_done;
        o_res_vld = 1'b0;
        o_res     = '0;
        if (i_fire) begin
            unique case (i_item.req_type)
                REQ_BEGIN: begin
                    n_crc    = CRC_INIT;
                    n_rcvd   = '0;
                    n_flen   = '0;
                    n_fn     = '0;
                    n_cnt    = '0;
                    n_hi     = '0;
                    n_crc_lo = '0;
                    n_emit   = '0;
                    n_want   = (i_item.expected_words > MaxW) ? MaxW
                                                              : i_item.expected_words;
                    n_done   = 1'b0;
                end
                REQ_TIMEOUT: begin
                    if (!r_done) begin
                        n_done            = 1'b1;
                        o_res_vld         = 1'b1;
                        o_res.result_kind = KIND_STATUS;
                        o_res.status_code = (r_rcvd == '0) ? ST_TIMEOUT : ST_FRAME;
                    end
                end
                REQ_BYTE: begin
                    if (!r_done) begin
                        n_rcvd = r_rcvd + 9'd1;
                        if (r_flen != '0 && w_pos_p2 >= {1'b0, r_flen}) begin
                            // trailing crc octets, low first
                            if (w_pos_p2 == {1'b0, r_flen}) begin
                                n_crc_lo = i_item.rx_byte;
                            end else begin
                                n_done            = 1'b1;
                                o_res_vld         = 1'b1;
                                o_res.result_kind = KIND_STATUS;
                                if (w_rx_crc != r_crc) begin
                                    o_res.status_code = ST_CRC;
                                end else if ((r_fn & FN_EXC_MASK) != '0) begin
                                    o_res.status_code    = ST_EXCEPTION;
                                    o_res.exception_code = r_cnt;
                                end else if (r_want != '0 && r_cnt != w_twice_want) begin
                                    o_res.status_code = ST_FRAME;
                                end else begin
                                    o_res.status_code = ST_OK;
                                end
                            end
                        end else begin
                            n_crc = crc16_feed(r_crc, i_item.rx_byte);
                            if (r_rcvd == 9'd1) begin
                                // function code sets the length where it can
                                n_fn = i_item.rx_byte;
                                if ((i_item.rx_byte & FN_EXC_MASK) != '0) begin
                                    n_flen = LEN_EXCEPTION;
                                end else if (!is_read_fn(i_item.rx_byte)) begin
                                    n_flen = LEN_FIXED;
                                end
                            end else if (r_rcvd == 9'd2) begin
                                // byte count, or exception code
                                n_cnt = i_item.rx_byte;
                                if (is_read_fn(r_fn)) begin
                                    n_flen = LEN_READ_BASE + {1'b0, i_item.rx_byte};
                                end
                            end else if (r_rcvd >= 9'd3 && is_read_fn(r_fn)) begin
                                // data octets pair up big-endian
                                if (r_rcvd[0]) begin
                                    n_hi = i_item.rx_byte;
                                end else if (r_emit < MaxW) begin
                                    o_res_vld         = 1'b1;
                                    o_res.result_kind = KIND_WORD;
                                    o_res.word_value  = {r_hi, i_item.rx_byte};
                                    o_res.word_index  = r_emit;
                                    n_emit            = r_emit + 7'd1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    // unused request code, ignored
                end
            endcase
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_rcvd   <= '0;
            r_flen   <= '0;
            r_fn     <= '0;
            r_cnt    <= '0;
            r_hi     <= '0;
            r_crc_lo <= '0;
            r_want   <= '0;
            r_emit   <= '0;
            r_done   <= 1'b1;
        end else begin
            r_crc    <= n_crc;
            r_rcvd   <= n_rcvd;
            r_flen   <= n_flen;
            r_fn     <= n_fn;
            r_cnt    <= n_cnt;
            r_hi     <= n_hi;
            r_crc_lo <= n_crc_lo;
            r_want   <= n_want;
            r_emit   <= n_emit;
            r_done   <= n_done;
        end
    end

    // a begin always opens the receiver
    a_begin_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.req_type == REQ_BEGIN |=> !r_done)
        else $error("receiver not open after begin");

    // a status result closes the frame
    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.result_kind == KIND_STATUS |=> r_done)
        else $error("frame still open after status");

    // words come only from read frames
    a_word_read_fn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.result_kind == KIND_WORD |->
            (r_fn == FN_READ_HOLD || r_fn == FN_READ_INPUT))
        else $error("word emitted outside a read frame");

    // word count never passes the limit
    a_emit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= MaxW)
        else $error("word count above limit");

    // exception code only with exception status
    a_exc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && o_res.status_code != ST_EXCEPTION |-> o_res.exception_code == '0)
        else $error("exception code on non-exception result");

endmodule

### hw/rtl/modbus_rtu_response_deframer.sv
// modbus_rtu_response_deframer: top level with input and result registers
// around mrd_engine; depends on mrd_pkg, mrd_channels and mrd_engine
//
//   channel  modport  direction  moves
//   i_in     sink     in         request: begin, received byte, timeout
//   o_out    source   out        result: register word or final status
//
// one item per cycle sustained while o_out.ready stays high; each item goes
// through the input register, then the combinational crc-16 byte update and
// frame decision, then the result register; reset (synchronous, i_rst_n low)
// empties both registers and idles the receiver until a begin; a stalled
// result holds one more item in the input register, then i_in.ready drops
module modbus_rtu_response_deframer #(
    parameter int MAX_WORDS = mrd_pkg::MAX_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrd_in_if.sink     i_in,
    mrd_out_if.source  o_out
);
    import mrd_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      w_proc;
    logic      w_res_vld;
    t_out_item w_res;

    // the held item moves on when the result slot is free or draining
    assign w_proc     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.req_type       <= i_in.req_type;
            r_in.rx_byte        <= i_in.rx_byte;
            r_in.expected_words <= i_in.expected_words;
        end
    end

    mrd_engine #(
        .MAX_WORDS (MAX_WORDS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_proc),
        .i_item    (r_in),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= w_res_vld;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.result_kind    = r_out.result_kind;
    assign o_out.word_value     = r_out.word_value;
    assign o_out.word_index     = r_out.word_index;
    assign o_out.status_code    = r_out.status_code;
    assign o_out.exception_code = r_out.exception_code;

endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for modbus_rtu_response_deframer, a directed
// table then random response frames checked against an in-bench predictor
// depends on mrd_pkg, mrd_channels and the deframer rtl
module tb_top;
    import mrd_pkg::*;

    localparam int         WORD_LIMIT    = MAX_WORDS_DEF;
    localparam int         RAND_ITEMS    = 950;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam t_out_item  NO_RES        = '0;

    // how a directed row gets its byte
    typedef enum logic [1:0] {FILL_NONE, FILL_CRC_LO, FILL_CRC_HI} t_fill;

    // response shapes built by the random part
    typedef enum logic [1:0] {FR_READ, FR_EXC, FR_OTHER} t_frame;

    typedef struct {
        logic [1:0] rt;
        logic [7:0] rb;
        logic [6:0] ew;
        t_fill      fill;
        bit         has_res;
        t_out_item  res;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    logic i_clk;
    logic i_rst_n;

    mrd_in_if  req_ch ();
    mrd_out_if res_ch ();

    modbus_rtu_response_deframer #(
        .MAX_WORDS (WORD_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // receiver state as the bench sees it
    logic [15:0] crc_acc;
    logic [8:0]  rx_count;
    logic [8:0]  frame_len;
    logic [7:0]  fn_code;
    logic [7:0]  cnt_byte;
    logic [7:0]  hi_byte;
    logic [7:0]  crc_lo;
    logic [6:0]  want_words;
    logic [6:0]  words_out;
    logic        rx_idle;

    // words and statuses still to come out, oldest first
    t_out_item   deframed_q [$];

    int          burst_left;
    int          live_items;
    int          err_count;
    int unsigned cycle_cnt;

    t_dir_row    dir_tab [DIR_ROWS];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and watchdog
    initial cycle_cnt = 0;
    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt == CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // reflected crc-16, lsb first
    function automatic logic [15:0] crc16_acc(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic t_out_item word_item(input logic [15:0] v, input logic [6:0] idx);
        t_out_item r;
        r = '0;
        r.result_kind = KIND_WORD;
        r.word_value  = v;
        r.word_index  = idx;
        return r;
    endfunction

    function automatic t_out_item status_item(input logic [2:0] st, input logic [7:0] exc);
        t_out_item r;
        r = '0;
        r.result_kind    = KIND_STATUS;
        r.status_code    = st;
        r.exception_code = exc;
        return r;
    endfunction

    // advance the receiver by one request, return the word or status it causes
    function automatic void deframe_predict(input t_in_item it, output bit made,
                                            output t_out_item res);
        logic [8:0]  pos;
        logic [15:0] rx_crc;
        logic [2:0]  st;
        bit          rd;
        made = 1'b0;
        res  = '0;
        rd   = (fn_code == FN_READ_HOLD) || (fn_code == FN_READ_INPUT);
        if (it.req_type == REQ_BEGIN) begin
            crc_acc    = CRC_INIT;
            rx_count   = '0;
            frame_len  = '0;
            fn_code    = '0;
            cnt_byte   = '0;
            hi_byte    = '0;
            crc_lo     = '0;
            words_out  = '0;
            want_words = (int'(it.expected_words) > WORD_LIMIT) ? 7'(WORD_LIMIT)
                                                                : it.expected_words;
            rx_idle    = 1'b0;
        end else if (it.req_type == REQ_TIMEOUT) begin
            if (!rx_idle) begin
                rx_idle = 1'b1;
                made    = 1'b1;
                res     = status_item((rx_count == 0) ? ST_TIMEOUT : ST_FRAME, 8'h00);
            end
        end else if (it.req_type == REQ_BYTE && !rx_idle) begin
            pos      = rx_count;
            rx_count = rx_count + 9'd1;
            if (frame_len != 0 && int'(pos) + 2 >= int'(frame_len)) begin
                // crc octets, low first; the second one closes the frame
                if (int'(pos) + 2 == int'(frame_len)) begin
                    crc_lo = it.rx_byte;
                end else begin
                    rx_idle = 1'b1;
                    made    = 1'b1;
                    rx_crc  = {it.rx_byte, crc_lo};
                    if (rx_crc != crc_acc)
                        st = ST_CRC;
                    else if (fn_code[7])
                        st = ST_EXCEPTION;
                    else if (want_words != 0 && int'(cnt_byte) != 2 * int'(want_words))
                        st = ST_FRAME;
                    else
                        st = ST_OK;
                    res = status_item(st, (st == ST_EXCEPTION) ? cnt_byte : 8'h00);
                end
            end else begin
                crc_acc = crc16_acc(crc_acc, it.rx_byte);
                if (pos == 9'd1) begin
                    fn_code = it.rx_byte;
                    if (it.rx_byte[7])
                        frame_len = LEN_EXCEPTION;
                    else if (it.rx_byte != FN_READ_HOLD && it.rx_byte != FN_READ_INPUT)
                        frame_len = LEN_FIXED;
                end else if (pos == 9'd2) begin
                    cnt_byte = it.rx_byte;
                    if (rd)
                        frame_len = LEN_READ_BASE + {1'b0, it.rx_byte};
                end else if (pos >= 9'd3 && rd) begin
                    // data octets pair up big-endian from offset 3
                    if (pos[0]) begin
                        hi_byte = it.rx_byte;
                    end else if (int'(words_out) < WORD_LIMIT) begin
                        made      = 1'b1;
                        res       = word_item({hi_byte, it.rx_byte}, words_out);
                        words_out = words_out + 7'd1;
                    end
                end
            end
        end
    endfunction

    // one request transfer, with burst and gap pacing on the sender side
    task automatic send_item(input logic [1:0] rt, input logic [7:0] rb,
                             input logic [6:0] ew, input bit typed,
                             input bit has_res, input t_out_item want);
        t_in_item  it;
        t_out_item r;
        bit        made;
        it.req_type       = rt;
        it.rx_byte        = rb;
        it.expected_words = ew;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= rt;
        req_ch.rx_byte        <= rb;
        req_ch.expected_words <= ew;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (rt == REQ_BEGIN || (!rx_idle && rt != REQ_UNUSED))
            live_items++;
        deframe_predict(it, made, r);
        if (typed) begin
            if (has_res)
                deframed_q.push_back(want);
        end else if (made) begin
            deframed_q.push_back(r);
        end
        burst_left--;
        if (burst_left == 0)
            req_ch.valid <= 1'b0;
    endtask

    task automatic put_req(input logic [1:0] rt, input logic [7:0] rb, input logic [6:0] ew);
        send_item(rt, rb, ew, 1'b0, 1'b0, NO_RES);
    endtask

    // sender goes quiet until every awaited result has come out
    task automatic hold_until_drained();
        if (burst_left != 0) begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
        end
        while (deframed_q.size() != 0) @(posedge i_clk);
    endtask

    // build one response with its crc and send it after a begin;
    // size 1 is a large read, size 2 the largest one
    task automatic send_frame(input t_frame shape, input int size, input bit cut_short);
        logic [7:0]  fb [$];
        logic [15:0] crc;
        logic [7:0]  fn;
        logic [6:0]  ew;
        int          cnt;
        int          stop;
        fb.push_back(8'($urandom_range(0, 255)));
        case (shape)
            FR_READ: begin
                fn = $urandom_range(0, 1) ? FN_READ_HOLD : FN_READ_INPUT;
                if (size == 2)
                    cnt = 255;
                else if (size == 1)
                    cnt = $urandom_range(248, 255);
                else
                    cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(0, 12);
                fb.push_back(fn);
                fb.push_back(8'(cnt));
                repeat (cnt) fb.push_back(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 5))
                    0: ew = '0;
                    1: ew = 7'($urandom_range(0, 127));
                    2: ew = (size != 0) ? 7'($urandom_range(124, 127)) : 7'(cnt / 2 + 1);
                    default: ew = (cnt / 2 > 127) ? 7'd127 : 7'(cnt / 2);
                endcase
            end
            FR_EXC: begin
                fb.push_back(8'($urandom_range(128, 255)));
                fb.push_back(8'($urandom_range(0, 255)));
                ew = 7'($urandom_range(0, 127));
            end
            default: begin
                do fn = 8'($urandom_range(0, 127));
                while (fn == FN_READ_HOLD || fn == FN_READ_INPUT);
                fb.push_back(fn);
                repeat (4) fb.push_back(8'($urandom_range(0, 255)));
                ew = 7'($urandom_range(0, 127));
            end
        endcase
        crc = CRC_INIT;
        foreach (fb[k]) crc = crc16_acc(crc, fb[k]);
        // now and then a corrupted checksum
        if ($urandom_range(0, 9) == 0)
            crc = crc ^ 16'($urandom_range(1, 65535));
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        stop = cut_short ? $urandom_range(1, fb.size() - 1) : fb.size();
        put_req(REQ_BEGIN, 8'($urandom_range(0, 255)), ew);
        for (int k = 0; k < stop; k++)
            put_req(REQ_BYTE, fb[k], 7'($urandom_range(0, 127)));
        if (cut_short) begin
            put_req(REQ_TIMEOUT, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        end else begin
            // late octets and a late timeout are dropped by a finished receiver
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    put_req(REQ_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            if ($urandom_range(0, 7) == 0)
                put_req(REQ_TIMEOUT, 8'h00, 7'd0);
        end
    endtask

    // result side stalls on a rotating 16-bit ready pattern that is redrawn periodically
    initial begin
        logic [15:0] stall_pat;
        int unsigned step;
        res_ch.ready = 1'b0;
        stall_pat    = 16'hFFFF;
        step         = 0;
        forever begin
            @(posedge i_clk);
            if (step % 64 == 0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom()) | 16'h0001);
            res_ch.ready <= stall_pat[step % 16];
            step++;
        end
    end

    // result checker
    initial err_count = 0;
    always @(posedge i_clk) begin
        t_out_item want_r;
        t_out_item got_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_r.result_kind    = res_ch.result_kind;
            got_r.word_value     = res_ch.word_value;
            got_r.word_index     = res_ch.word_index;
            got_r.status_code    = res_ch.status_code;
            got_r.exception_code = res_ch.exception_code;
            if (deframed_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, got kind %0d value %h",
                         $time, got_r.result_kind, got_r.word_value);
            end else begin
                want_r = deframed_q.pop_front();
                if (got_r.result_kind !== want_r.result_kind
                    || got_r.word_value !== want_r.word_value
                    || got_r.word_index !== want_r.word_index
                    || got_r.status_code !== want_r.status_code
                    || got_r.exception_code !== want_r.exception_code) begin
                    err_count++;
                    $display({"%0t: result mismatch, expected kind %0d value %h index %0d",
                              " status %0d exc %h, got kind %0d value %h index %0d",
                              " status %0d exc %h"}, $time,
                             want_r.result_kind, want_r.word_value, want_r.word_index,
                             want_r.status_code, want_r.exception_code,
                             got_r.result_kind, got_r.word_value, got_r.word_index,
                             got_r.status_code, got_r.exception_code);
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [7:0] rb;
        int         sel;
        bit         paused;
        i_rst_n               = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_BEGIN;
        req_ch.rx_byte        = 8'h00;
        req_ch.expected_words = 7'd0;
        burst_left            = 0;
        live_items            = 0;
        paused                = 1'b0;
        crc_acc               = CRC_INIT;
        rx_count              = '0;
        frame_len             = '0;
        fn_code               = '0;
        cnt_byte              = '0;
        hi_byte               = '0;
        crc_lo                = '0;
        want_words            = '0;
        words_out             = '0;
        rx_idle               = 1'b1;

        dir_tab = '{
            // idle after reset: octets, timeouts and the spare code do nothing
            '{REQ_BYTE,    8'h55, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_TIMEOUT, 8'h00, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_UNUSED,  8'hFF, 7'd127, FILL_NONE,   1'b0, NO_RES},
            // open then expire with no octets
            '{REQ_BEGIN,   8'h00, 7'd127, FILL_NONE,   1'b0, NO_RES},
            '{REQ_TIMEOUT, 8'h00, 7'd0,   FILL_NONE,   1'b1, status_item(ST_TIMEOUT, 8'h00)},
            // expire after one octet: short frame
            '{REQ_BEGIN,   8'hFF, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h01, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_TIMEOUT, 8'hFF, 7'd127, FILL_NONE,   1'b1, status_item(ST_FRAME, 8'h00)},
            // read of two registers, good crc, then a late octet
            '{REQ_BEGIN,   8'h00, 7'd2,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h01, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h03, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h04, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h12, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h34, 7'd0,   FILL_NONE,   1'b1, word_item(16'h1234, 7'd0)},
            '{REQ_BYTE,    8'hAB, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'hCD, 7'd0,   FILL_NONE,   1'b1, word_item(16'hABCD, 7'd1)},
            '{REQ_BYTE,    8'h00, 7'd0,   FILL_CRC_LO, 1'b0, NO_RES},
            '{REQ_BYTE,    8'h00, 7'd0,   FILL_CRC_HI, 1'b1, status_item(ST_OK, 8'h00)},
            '{REQ_BYTE,    8'h00, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            // exception reply carries its code out with the status
            '{REQ_BEGIN,   8'h00, 7'd5,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'hFF, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h83, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h02, 7'd0,   FILL_NONE,   1'b0, NO_RES},
            '{REQ_BYTE,    8'h00, 7'd0,   FILL_CRC_LO, 1'b0, NO_RES},
            '{REQ_BYTE,    8'h00, 7'd0,   FILL_CRC_HI, 1'b1, status_item(ST_EXCEPTION, 8'h02)}
        };

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; checksum octets come from the running crc
        for (int i = 0; i < DIR_ROWS; i++) begin
            rb = dir_tab[i].rb;
            if (dir_tab[i].fill == FILL_CRC_LO)
                rb = crc_acc[7:0];
            else if (dir_tab[i].fill == FILL_CRC_HI)
                rb = crc_acc[15:8];
            send_item(dir_tab[i].rt, rb, dir_tab[i].ew, 1'b1,
                      dir_tab[i].has_res, dir_tab[i].res);
        end

        // random frames, opening with one that runs past the word limit
        live_items = 0;
        send_frame(FR_READ, 2, 1'b0);
        while (live_items < RAND_ITEMS) begin
            if (!paused && live_items >= RAND_ITEMS / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_frame(FR_READ, ($urandom_range(0, 49) == 0) ? 1 : 0, 1'b0);
            end else if (sel < 58) begin
                send_frame(FR_EXC, 0, 1'b0);
            end else if (sel < 70) begin
                send_frame(FR_OTHER, 0, 1'b0);
            end else if (sel < 82) begin
                send_frame(t_frame'($urandom_range(0, 2)), 0, 1'b1);
            end else if (sel < 90) begin
                put_req(REQ_BEGIN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
                put_req(REQ_TIMEOUT, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end else begin
                // noise: any request code with random content
                repeat ($urandom_range(1, 6))
                    put_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            7'($urandom_range(0, 127)));
            end
        end

        // drain and let the pipeline settle
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && deframed_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
